>>> rtl/bfa_pkg.sv
package bfa_pkg;

  localparam int unsigned FRAC_BITS = 32;
  localparam int unsigned INT_W     = 19;
  localparam int unsigned INT_OUT_W = 20;
  localparam int unsigned DEN_W     = 32;
  localparam int unsigned PROD_W    = 2 * DEN_W;
  localparam int unsigned PC_W      = 4;
  localparam int unsigned DIV_STEPS = FRAC_BITS + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // datapath operations, one per microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MUL_FD,
    OP_CLASS,
    OP_DIV_ONE,
    OP_DIV_XR,
    OP_MUL_DEN,
    OP_DEN_UPD,
    OP_MUL_NUM,
    OP_NUM_UPD,
    OP_EMIT
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_EDGE,
    CND_RZERO,
    CND_OVER
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    op_e  op;
    logic fire;
    logic div_start;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic edge_hit;
    logic r_zero;
    logic over;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/bfa_div.sv
module bfa_div
  import bfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FRAC_BITS:0]   dividend_i,
  input  logic [DEN_W-1:0]     divisor_i,
  output logic                 done_o,
  output logic [DEN_W-1:0]     quot_o,
  output logic [DEN_W-1:0]     rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [FRAC_BITS:0]   qr_q, qr_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [DEN_W-1:0]     dvs_q, dvs_d;
  logic [DEN_W:0]       rs;
  logic [DEN_W+1:0]     diff;
  logic                 ge;

  // one restoring step per cycle, dividend bits enter msb first
  assign rs   = {rem_q, qr_q[FRAC_BITS]};
  assign diff = {1'b0, rs} - {2'b00, dvs_q};
  assign ge   = ~diff[DEN_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    qr_d   = qr_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      qr_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
      qr_d  = {qr_q[FRAC_BITS-1:0], ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qr_q  <= qr_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = qr_q[DEN_W-1:0];
  assign rem_o  = rem_q;

endmodule

>>> rtl/bfa_useq.sv
module bfa_useq
  import bfa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  // microcode addresses
  localparam logic [PC_W-1:0] S_IDLE    = PC_W'(0);
  localparam logic [PC_W-1:0] S_MUL_FD  = PC_W'(1);
  localparam logic [PC_W-1:0] S_CLASS   = PC_W'(2);
  localparam logic [PC_W-1:0] S_DIV_ONE = PC_W'(3);
  localparam logic [PC_W-1:0] S_LOOP    = PC_W'(4);
  localparam logic [PC_W-1:0] S_DIV_XR  = PC_W'(5);
  localparam logic [PC_W-1:0] S_MUL_DEN = PC_W'(6);
  localparam logic [PC_W-1:0] S_DEN_UPD = PC_W'(7);
  localparam logic [PC_W-1:0] S_MUL_NUM = PC_W'(8);
  localparam logic [PC_W-1:0] S_NUM_UPD = PC_W'(9);
  localparam logic [PC_W-1:0] S_EMIT    = PC_W'(10);

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      S_IDLE:    w = '{op: OP_ACCEPT,  cond: CND_NEVER,  target: S_IDLE};
      S_MUL_FD:  w = '{op: OP_MUL_FD,  cond: CND_NEVER,  target: S_IDLE};
      S_CLASS:   w = '{op: OP_CLASS,   cond: CND_EDGE,   target: S_EMIT};
      S_DIV_ONE: w = '{op: OP_DIV_ONE, cond: CND_NEVER,  target: S_IDLE};
      S_LOOP:    w = '{op: OP_NOP,     cond: CND_RZERO,  target: S_EMIT};
      S_DIV_XR:  w = '{op: OP_DIV_XR,  cond: CND_NEVER,  target: S_IDLE};
      S_MUL_DEN: w = '{op: OP_MUL_DEN, cond: CND_NEVER,  target: S_IDLE};
      S_DEN_UPD: w = '{op: OP_DEN_UPD, cond: CND_OVER,   target: S_EMIT};
      S_MUL_NUM: w = '{op: OP_MUL_NUM, cond: CND_NEVER,  target: S_IDLE};
      S_NUM_UPD: w = '{op: OP_NUM_UPD, cond: CND_ALWAYS, target: S_LOOP};
      S_EMIT:    w = '{op: OP_EMIT,    cond: CND_ALWAYS, target: S_IDLE};
      default:   w = '{op: OP_NOP,     cond: CND_ALWAYS, target: S_IDLE};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_q, pc_d;
  logic            div_wait_q, div_wait_d;
  ucode_t          uw;
  logic            is_div;
  logic            hold;
  logic            fire;
  logic            jump;

  assign uw     = ucode(pc_q);
  assign is_div = (uw.op == OP_DIV_ONE) || (uw.op == OP_DIV_XR);

  always_comb begin
    hold = 1'b0;
    if (uw.op == OP_ACCEPT) begin
      hold = ~in_valid_i;
    end else if (is_div) begin
      hold = ~(div_wait_q & stat_i.div_done);
    end else if (uw.op == OP_EMIT) begin
      hold = stat_i.out_busy;
    end
  end

  assign fire = ~hold;

  always_comb begin
    unique case (uw.cond)
      CND_NEVER:  jump = 1'b0;
      CND_ALWAYS: jump = 1'b1;
      CND_EDGE:   jump = stat_i.edge_hit;
      CND_RZERO:  jump = stat_i.r_zero;
      CND_OVER:   jump = stat_i.over;
      default:    jump = 1'b1;
    endcase
  end

  always_comb begin
    pc_d       = pc_q;
    div_wait_d = div_wait_q;
    if (is_div && !div_wait_q) begin
      div_wait_d = 1'b1;
    end
    if (fire) begin
      pc_d       = jump ? uw.target : pc_q + PC_W'(1);
      div_wait_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= S_IDLE;
      div_wait_q <= 1'b0;
    end else begin
      pc_q       <= pc_d;
      div_wait_q <= div_wait_d;
    end
  end

  assign in_stall_o       = (uw.op != OP_ACCEPT);
  assign ctrl_o.op        = uw.op;
  assign ctrl_o.fire      = fire;
  assign ctrl_o.div_start = is_div & ~div_wait_q;

endmodule

>>> rtl/bfa_dpath.sv
module bfa_dpath
  import bfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  output stat_t                stat_o,
  input  logic                 cfg_we_i,
  input  logic [DEN_W-1:0]     cfg_wdata_i,
  input  logic [INT_W-1:0]     ratio_int_i,
  input  logic [FRAC_BITS-1:0] ratio_frac_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [INT_OUT_W-1:0] int_out_o,
  output logic [DEN_W-1:0]     numerator_o,
  output logic [DEN_W-1:0]     denominator_o
);

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [DEN_W-1:0]     lim_q;
  logic                 out_valid_q;
  logic [INT_OUT_W-1:0] nint_q, oint_q;
  logic [FRAC_BITS-1:0] f_q;
  logic [DEN_W-1:0]     d_q;
  logic [PROD_W-1:0]    prod_q;
  logic [DEN_W-1:0]     x_q, r_q, a_q, t_q;
  logic [DEN_W-1:0]     num0_q, num1_q, den0_q, den1_q;
  logic [DEN_W-1:0]     onum_q, oden_q;

  logic [DEN_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    gd;
  logic                 fd_small;
  logic                 gd_half;
  logic                 gd_small;
  logic [PROD_W:0]      den_sum;
  logic                 over;
  logic [FRAC_BITS:0]   div_dividend;
  logic [DEN_W-1:0]     div_divisor;
  logic                 div_done;
  logic [DEN_W-1:0]     div_quot, div_rem;
  logic                 fire;

  assign fire = ctrl_i.fire;

  // edge bands: f*d against 1/2 and 1, g*d = d*2^32 - f*d likewise
  assign gd       = {d_q, {FRAC_BITS{1'b0}}} - prod_q;
  assign fd_small = (prod_q[PROD_W-1:FRAC_BITS] == '0);
  assign gd_half  = (gd[PROD_W-1:FRAC_BITS-1] == '0);
  assign gd_small = (gd[PROD_W-1:FRAC_BITS] == '0);

  // next denominator reaches the limit
  assign den_sum = {1'b0, prod_q} + {{(PROD_W-DEN_W+1){1'b0}}, den0_q};
  assign over    = (den_sum >= {{(PROD_W-DEN_W+1){1'b0}}, d_q});

  // shared multiplier operands
  always_comb begin
    unique case (ctrl_i.op)
      OP_MUL_DEN: begin
        mul_a = den1_q;
        mul_b = a_q;
      end
      OP_MUL_NUM: begin
        mul_a = num1_q;
        mul_b = a_q;
      end
      default: begin
        mul_a = f_q;
        mul_b = d_q;
      end
    endcase
  end

  assign div_dividend = (ctrl_i.op == OP_DIV_ONE) ? ONE : {1'b0, x_q};
  assign div_divisor  = (ctrl_i.op == OP_DIV_ONE) ? f_q : r_q;

  bfa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      if (fire && ctrl_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      unique case (ctrl_i.op)
        OP_ACCEPT: begin
          f_q    <= ratio_frac_i;
          nint_q <= {1'b0, ratio_int_i};
          d_q    <= (lim_q < DEN_W'(2)) ? DEN_W'(2) : lim_q;
        end
        OP_MUL_FD, OP_MUL_DEN, OP_MUL_NUM: begin
          prod_q <= mul_a * mul_b;
        end
        OP_CLASS: begin
          den1_q <= d_q;
          priority if (fd_small) begin
            num1_q <= {{(DEN_W-1){1'b0}}, prod_q[FRAC_BITS-1]};
          end else if (gd_half) begin
            num1_q <= '0;
            nint_q <= nint_q + INT_OUT_W'(1);
          end else begin
            num1_q <= d_q - DEN_W'(1);
          end
        end
        OP_DIV_ONE: begin
          den0_q <= DEN_W'(1);
          den1_q <= div_quot;
          num0_q <= '0;
          num1_q <= DEN_W'(1);
          x_q    <= f_q;
          r_q    <= div_rem;
        end
        OP_DIV_XR: begin
          a_q <= div_quot;
          t_q <= div_rem;
        end
        OP_DEN_UPD: begin
          if (!over) begin
            den0_q <= den1_q;
            den1_q <= den_sum[DEN_W-1:0];
          end
        end
        OP_NUM_UPD: begin
          num0_q <= num1_q;
          num1_q <= prod_q[DEN_W-1:0] + num0_q;
          x_q    <= r_q;
          r_q    <= t_q;
        end
        OP_EMIT: begin
          oint_q <= nint_q;
          onum_q <= num1_q;
          oden_q <= den1_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.edge_hit = fd_small | gd_small;
  assign stat_o.r_zero   = (r_q == '0);
  assign stat_o.over     = over;
  assign stat_o.div_done = div_done;
  assign stat_o.out_busy = out_valid_q & out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign int_out_o     = oint_q;
  assign numerator_o   = onum_q;
  assign denominator_o = oden_q;

endmodule

>>> rtl/bounded_fraction_approximator.sv
// bounded rational approximation of a divider ratio: a request carries an integer part and a
// 32-bit binary fraction, and the result gives int + numerator/denominator with the denominator
// never above den_limit (a limit below 2 acts as 2). fractions within 1/(2D) of zero or one,
// and within 1/D of either, return fixed answers (0/D, 1/D, (D-1)/D, or 0/D with a carry into
// the integer part); all others return the last continued-fraction convergent whose denominator
// stays below the limit, found by exact integer euclid. one request is handled at a time: edge
// bands skip the euclid loop, and each euclid step runs on the bit-serial divider (one quotient
// bit per cycle) shared with a single 32x32 multiplier under a microcoded step sequencer. the
// result sits in an output register, so the next request is taken while it waits. den_limit
// must be written only while the block is idle; the block itself does not enforce this.
module bounded_fraction_approximator
  import bfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [DEN_W-1:0]     cfg_wdata_i,
  // request
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [INT_W-1:0]     ratio_int_i,
  input  logic [FRAC_BITS-1:0] ratio_frac_i,
  // result
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [INT_OUT_W-1:0] int_out_o,
  output logic [DEN_W-1:0]     numerator_o,
  output logic [DEN_W-1:0]     denominator_o
);

  ctrl_t ctrl;
  stat_t stat;

  // step counter and microcode rom, conditional jumps on datapath flags
  bfa_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // registers, shared multiplier, serial divider and output register
  bfa_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .ratio_int_i   (ratio_int_i),
    .ratio_frac_i  (ratio_frac_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .int_out_o     (int_out_o),
    .numerator_o   (numerator_o),
    .denominator_o (denominator_o)
  );

endmodule

>>> sim/testbench.sv
module testbench;
  import bfa_pkg::*;

  // one result of the approximation: integer part, numerator, denominator
  typedef struct packed {
    logic [INT_OUT_W-1:0] whole;
    logic [DEN_W-1:0]     num;
    logic [DEN_W-1:0]     den;
  } approx_t;

  // one row of the directed table; the expected result is typed in when known is set
  typedef struct packed {
    logic [DEN_W-1:0]     limit;
    logic [INT_W-1:0]     ri;
    logic [FRAC_BITS-1:0] rf;
    logic                 known;
    approx_t              want;
  } stim_row_t;

  localparam int N_DIRECTED = 24;
  localparam int N_PHASES   = 11;
  localparam int PHASE_REQS = 32;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [DEN_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [INT_W-1:0] ratio_int_i = '0;
  logic [FRAC_BITS-1:0] ratio_frac_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [INT_OUT_W-1:0] int_out_o;
  logic [DEN_W-1:0] numerator_o;
  logic [DEN_W-1:0] denominator_o;

  // results predicted for accepted requests, oldest first
  approx_t pending_results[$];
  int mismatches = 0;
  // limit as the block currently holds it
  logic [DEN_W-1:0] den_limit_now = 32'hFFFF_FFFF;
  // idling controls shared between the stimulus and the result side
  int request_gap_max = 16;
  int result_stall_max = 16;
  int result_hold = 0;

  always #5 clk_i = ~clk_i;

  bounded_fraction_approximator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .ratio_int_i   (ratio_int_i),
    .ratio_frac_i  (ratio_frac_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .int_out_o     (int_out_o),
    .numerator_o   (numerator_o),
    .denominator_o (denominator_o)
  );

  // x * d < k for d >= 1 and k >= 1, kept free of overflow
  function automatic bit mul_under(logic [63:0] x, logic [63:0] d, logic [63:0] k);
    return x <= (k - 64'd1) / d;
  endfunction

  // expected result of one request under the given limit
  function automatic approx_t approximate_ratio(logic [INT_W-1:0] ri,
                                                logic [FRAC_BITS-1:0] rf,
                                                logic [DEN_W-1:0] lim);
    logic [63:0] one, half, f, g, d, num, den;
    logic [63:0] num0, den0, num1, den1, x, r, a, need, t;
    logic [INT_OUT_W-1:0] whole;
    bit done;
    one   = 64'd1 << FRAC_BITS;
    half  = 64'd1 << (FRAC_BITS - 1);
    f     = 64'(rf);
    g     = one - f;
    // a limit below two behaves as two
    d     = (lim < 2) ? 64'd2 : 64'(lim);
    whole = INT_OUT_W'(ri);
    if (!mul_under(f, d, half) && mul_under(f, d, one)) begin
      // small fraction: one over the limit
      num = 64'd1;
      den = d;
    end else if (mul_under(f, d, half)) begin
      // rounds down to zero
      num = 64'd0;
      den = d;
    end else if (mul_under(g, d, half)) begin
      // rounds up to one, carried into the integer part
      num   = 64'd0;
      den   = d;
      whole = whole + 1'b1;
    end else if (mul_under(g, d, one)) begin
      num = d - 64'd1;
      den = d;
    end else begin
      // continued-fraction convergents by euclid on (2^FRAC_BITS, fraction)
      num0 = 64'd0;
      den0 = 64'd1;
      num1 = 64'd1;
      den1 = one / f;
      x    = f;
      r    = one % f;
      done = 1'b0;
      while (r != 64'd0 && !done) begin
        a    = x / r;
        need = (d - den0 + den1 - 64'd1) / den1;
        if (a >= need) begin
          done = 1'b1;
        end else begin
          t    = den1 * a + den0;
          den0 = den1;
          den1 = t;
          t    = num1 * a + num0;
          num0 = num1;
          num1 = t;
          t    = x % r;
          x    = r;
          r    = t;
        end
      end
      num = num1;
      den = den1;
    end
    return '{whole, num[DEN_W-1:0], den[DEN_W-1:0]};
  endfunction

  // fraction aimed at the interesting spots for the given limit: the band edges near
  // zero and one, exact rationals with small denominators, or anywhere at all
  function automatic logic [FRAC_BITS-1:0] pick_fraction(logic [DEN_W-1:0] lim);
    logic [63:0] d, base, q, p, v;
    int kind;
    d    = (lim < 2) ? 64'd2 : 64'(lim);
    base = (64'($urandom_range(0, 3)) << (FRAC_BITS - 1)) / d;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: v = base + 64'($urandom_range(0, 4)) - 64'd2;
      2, 3: v = (64'd1 << FRAC_BITS) - base + 64'($urandom_range(0, 4)) - 64'd2;
      4, 5: begin
        q = 64'($urandom_range(2, 1000));
        p = 64'($urandom_range(1, 32'(q) - 1));
        v = ((p << FRAC_BITS) / q) + 64'($urandom_range(0, 1));
      end
      default: v = 64'($urandom);
    endcase
    return v[FRAC_BITS-1:0];
  endfunction

  function automatic logic [INT_W-1:0] pick_int();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return INT_W'($urandom);
    endcase
  endfunction

  // offer one request after a gap, hold it until accepted, then log its expected result;
  // valid stays high on return so a back-to-back request follows without a bubble
  task automatic push_request(input logic [INT_W-1:0] ri, input logic [FRAC_BITS-1:0] rf,
                              input approx_t want);
    int gap;
    gap = (request_gap_max > 0) ? $urandom_range(0, request_gap_max) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    ratio_int_i  <= ri;
    ratio_frac_i <= rf;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(want);
  endtask

  // stop offering and wait until every result is back and the block is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [DEN_W-1:0] lim);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    den_limit_now = lim;
  endtask

  task automatic compare_field(input string field, input logic [DEN_W-1:0] want,
                               input logic [DEN_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  // directed table: bands at both ends, the small-limit clamp, carry out of the largest
  // integer part, exact halves and a few long euclid runs
  stim_row_t directed [N_DIRECTED] = '{
    '{32'hFFFF_FFFF, 19'h00000, 32'h0000_0000, 1'b1, '{20'h00000, 32'h0, 32'hFFFF_FFFF}},
    '{32'hFFFF_FFFF, 19'h7FFFF, 32'hFFFF_FFFF, 1'b1,
      '{20'h7FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF}},
    '{32'hFFFF_FFFF, 19'h00000, 32'h0000_0001, 1'b1, '{20'h00000, 32'h1, 32'hFFFF_FFFF}},
    '{32'hFFFF_FFFF, 19'h12345, 32'h8000_0000, 1'b1, '{20'h12345, 32'h1, 32'h2}},
    '{32'hFFFF_FFFF, 19'h00000, 32'h5555_5555, 1'b0, '0},
    '{32'hFFFF_FFFF, 19'h2AAAA, 32'hAAAA_AAAA, 1'b0, '0},
    '{32'hFFFF_FFFF, 19'h05555, 32'h9E37_79B9, 1'b0, '0},
    '{32'hFFFF_FFFF, 19'h00000, 32'h0000_0003, 1'b0, '0},
    '{32'hFFFF_FFFF, 19'h00000, 32'hFFFF_FFFE, 1'b0, '0},
    '{32'h0000_0000, 19'h00000, 32'h0000_0000, 1'b1, '{20'h00000, 32'h0, 32'h2}},
    '{32'h0000_0000, 19'h7FFFF, 32'hC000_0001, 1'b1, '{20'h80000, 32'h0, 32'h2}},
    '{32'h0000_0000, 19'h00000, 32'h4000_0000, 1'b1, '{20'h00000, 32'h1, 32'h2}},
    '{32'h0000_0000, 19'h00000, 32'h3FFF_FFFF, 1'b1, '{20'h00000, 32'h0, 32'h2}},
    '{32'h0000_0000, 19'h00000, 32'hC000_0000, 1'b1, '{20'h00000, 32'h1, 32'h2}},
    '{32'h0000_0001, 19'h00001, 32'h8000_0000, 1'b1, '{20'h00001, 32'h1, 32'h2}},
    '{32'h0000_0001, 19'h00000, 32'hFFFF_FFFF, 1'b1, '{20'h00001, 32'h0, 32'h2}},
    '{32'h0000_0002, 19'h00003, 32'h7FFF_FFFF, 1'b0, '0},
    '{32'h0000_0003, 19'h00000, 32'h5555_5555, 1'b0, '0},
    '{32'h0000_0003, 19'h00000, 32'h5555_5556, 1'b0, '0},
    '{32'h0000_0003, 19'h00000, 32'hAAAA_AAAB, 1'b0, '0},
    '{32'h0000_03E8, 19'h00100, 32'h0041_8937, 1'b0, '0},
    '{32'h0000_03E8, 19'h00000, 32'hFFBE_76C9, 1'b0, '0},
    '{32'h8000_0000, 19'h00000, 32'h0000_0001, 1'b1, '{20'h00000, 32'h1, 32'h8000_0000}},
    '{32'h8000_0000, 19'h00000, 32'hFFFF_FFFF, 1'b1,
      '{20'h00000, 32'h7FFF_FFFF, 32'h8000_0000}}
  };

  // stimulus: directed table, then random phases each under its own limit
  initial begin
    logic [DEN_W-1:0] lim;
    logic [INT_W-1:0] ri;
    logic [FRAC_BITS-1:0] rf;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].limit != den_limit_now) begin
        settle();
        write_limit(directed[i].limit);
      end
      push_request(directed[i].ri, directed[i].rf,
                   directed[i].known ? directed[i].want
                                     : approximate_ratio(directed[i].ri, directed[i].rf,
                                                         den_limit_now));
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       lim = $urandom;
        1:       lim = 32'hFFFF_FFFF;
        2:       lim = 32'd2;
        3:       lim = 32'd3;
        4:       lim = 32'd5;
        5:       lim = DEN_W'($urandom_range(6, 65535));
        6:       lim = 32'h8000_0000;
        7:       lim = 32'hFFFF_FFFE;
        8:       lim = 32'd0;
        9:       lim = 32'd1;
        default: lim = DEN_W'($urandom_range(10, 1000));
      endcase
      settle();
      write_limit(lim);
      // every third phase runs with no idling on either side
      request_gap_max  = (ph % 3 == 1) ? 0 : 16;
      result_stall_max = (ph % 3 == 1) ? 0 : 16;
      if (ph == 2) begin
        // long result hold-off while requests keep coming back to back, so the output
        // register fills and the block has to stall its request side
        request_gap_max = 0;
        result_hold     = 600;
      end
      for (int n = 0; n < PHASE_REQS; n++) begin
        ri = pick_int();
        rf = pick_fraction(den_limit_now);
        push_request(ri, rf, approximate_ratio(ri, rf, den_limit_now));
      end
    end

    settle();
    repeat (50) @(posedge clk_i);
    if (pending_results.size() > 0) begin
      mismatches += pending_results.size();
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    if (mismatches == 0) begin
      $display("bounded_fraction_approximator regression: pass");
    end else begin
      $display("bounded_fraction_approximator regression: fail");
    end
    $finish;
  end

  // result side: random stall before each result, a long hold-off when asked for,
  // and a field-by-field check against the oldest expectation
  initial begin
    approx_t want;
    int hold;
    forever begin
      if (result_hold > 0) begin
        hold        = result_hold;
        result_hold = 0;
      end else begin
        hold = (result_stall_max > 0) ? $urandom_range(0, result_stall_max) : 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual %0h %0h/%0h", $time,
                 int_out_o, numerator_o, denominator_o);
      end else begin
        want = pending_results.pop_front();
        compare_field("int_out", DEN_W'(want.whole), DEN_W'(int_out_o));
        compare_field("numerator", want.num, numerator_o);
        compare_field("denominator", want.den, denominator_o);
      end
    end
  end

  // watchdog, sized well past the slowest legal run
  initial begin
    #30_000_000;
    $display("%0t: timeout", $time);
    $display("bounded_fraction_approximator regression: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/bfa_pkg.sv
rtl/bfa_div.sv
rtl/bfa_useq.sv
rtl/bfa_dpath.sv
rtl/bounded_fraction_approximator.sv
sim/testbench.sv
